@@ src/slcr_pkg.sv @@
// Shared types and constants for the sync level calibration receiver.
// Used by slcr_bitclk, slcr_cell and sync_level_calibration_receiver.
package slcr_pkg;

  // samples per bit and length of the level window
  localparam int SAMPLES_PER_BIT = 10;
  localparam int WINDOW_LEN      = 24;

  localparam int SAMPLE_W = 16;
  localparam int HIST_W   = 24;
  localparam int PHASE_W  = 16;

  localparam int PHASE_INC_I   = 65536 / SAMPLES_PER_BIT;
  localparam int PHASE_NUDGE_I = PHASE_INC_I / 32;
  localparam logic [PHASE_W:0] PHASE_INC   = (PHASE_W + 1)'(PHASE_INC_I);
  localparam logic [PHASE_W:0] PHASE_NUDGE = (PHASE_W + 1)'(PHASE_NUDGE_I);

  localparam int SCAN_LEN = (WINDOW_LEN > HIST_W) ? WINDOW_LEN : HIST_W;
  localparam int CNT_W    = $clog2(SCAN_LEN);
  localparam int HIDX_W   = $clog2(HIST_W);
  localparam int ERR_W    = $clog2(HIST_W + 1);

  localparam logic signed [SAMPLE_W-1:0] START_MAX = -16'sd16000;
  localparam logic signed [SAMPLE_W-1:0] START_MIN = 16'sd16000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPREAD   = 2'd2;

  localparam logic [HIST_W-1:0] SYNC_RESET   = 24'hAAB468;
  localparam logic [3:0]        ERRORS_RESET = 4'd2;
  localparam logic [15:0]       SPREAD_RESET = 16'd5;

  // running max/min handed from cell to cell during a scan
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] lo;
  } tok_t;

  // bit clock status toward the top level
  typedef struct packed {
    logic              take;
    logic [HIST_W-1:0] hist;
  } bclk_stat_t;

endpackage

@@ src/slcr_bitclk.sv @@
// Bit clock recovery: phase accumulator with zero-crossing nudge and the
// history of bit decisions. Depends on slcr_pkg.
module slcr_bitclk (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic signed [slcr_pkg::SAMPLE_W-1:0] sample,
  output slcr_pkg::bclk_stat_t                 stat
);

  logic [slcr_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                         last_sign_r;
  logic [slcr_pkg::HIST_W-1:0]  hist_r, hist_nxt;
  logic [slcr_pkg::PHASE_W:0]   ph_nudged;
  logic [slcr_pkg::PHASE_W:0]   ph_sum;
  logic                         neg;

  assign neg = sample[slcr_pkg::SAMPLE_W-1];

  always_comb begin
    ph_nudged = {1'b0, phase_r};
    // on a sign change, pull the phase toward the half turn
    if (neg != last_sign_r) begin
      if (phase_r[slcr_pkg::PHASE_W-1]) begin
        ph_nudged = {1'b0, phase_r} - slcr_pkg::PHASE_NUDGE;
      end else begin
        ph_nudged = {1'b0, phase_r} + slcr_pkg::PHASE_NUDGE;
      end
    end
    ph_sum    = ph_nudged + slcr_pkg::PHASE_INC;
    phase_nxt = ph_sum[slcr_pkg::PHASE_W-1:0];
    hist_nxt  = {hist_r[slcr_pkg::HIST_W-2:0], neg};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      last_sign_r <= 1'b0;
      hist_r      <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      last_sign_r <= neg;
      if (ph_sum[slcr_pkg::PHASE_W]) begin
        hist_r <= hist_nxt;
      end
    end
  end

  assign stat.take = ph_sum[slcr_pkg::PHASE_W];
  assign stat.hist = hist_r;

endmodule

@@ src/slcr_cell.sv @@
// One window cell: holds one bit sample, shifts it on toward the next cell
// and folds it into the passing max/min token. Depends on slcr_pkg.
module slcr_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift,
  input  logic signed [slcr_pkg::SAMPLE_W-1:0] smp_in,
  output logic signed [slcr_pkg::SAMPLE_W-1:0] smp_out,
  input  slcr_pkg::tok_t                       tok_in,
  output slcr_pkg::tok_t                       tok_out
);

  logic signed [slcr_pkg::SAMPLE_W-1:0] sample_r;
  logic                                 tok_valid_r;
  logic signed [slcr_pkg::SAMPLE_W-1:0] hi_r, hi_nxt;
  logic signed [slcr_pkg::SAMPLE_W-1:0] lo_r, lo_nxt;

  always_comb begin
    hi_nxt = (sample_r > tok_in.hi) ? sample_r : tok_in.hi;
    lo_nxt = (sample_r < tok_in.lo) ? sample_r : tok_in.lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r    <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      if (shift) begin
        sample_r <= smp_in;
      end
      tok_valid_r <= tok_in.valid;
    end
  end

  // hold the token values once it has passed
  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign smp_out       = sample_r;
  assign tok_out.valid = tok_valid_r;
  assign tok_out.hi    = hi_r;
  assign tok_out.lo    = lo_r;

endmodule

@@ src/sync_level_calibration_receiver.sv @@
// Top level of the sync level calibration receiver: configuration registers,
// cell chain, scan control and output register.
// Depends on slcr_pkg, slcr_bitclk and slcr_cell.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid / in_stall   | in_sample
//   out     | output    | out_valid / out_stall | out_inverted, out_level_max, out_level_min
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A sample that is not a bit decision does not stall the input. A bit decision shifts
// into the cell chain and starts a scan: the max/min token walks the 24 cells
// while the sync errors are counted one bit a cycle, then the evaluate state
// waits for the output to be free. in_stall is high during the scan and the
// evaluate state, so no new sample is taken until the evaluation is done.
// Reset clears the cell samples, phase and history and loads the configuration defaults at once; no sweep.
module sync_level_calibration_receiver (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [slcr_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_inverted,
  output logic signed [slcr_pkg::SAMPLE_W-1:0]   out_level_max,
  output logic signed [slcr_pkg::SAMPLE_W-1:0]   out_level_min,
  input  logic                                   cfg_we,
  input  logic [slcr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [slcr_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [slcr_pkg::HIST_W-1:0] sync_r;
  logic [3:0]                  max_err_r;
  logic [15:0]                 min_spread_r;

  logic                        in_acc;
  logic                        shift;
  slcr_pkg::bclk_stat_t        bstat;

  logic [slcr_pkg::CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [slcr_pkg::ERR_W-1:0]  err_cnt_r, err_cnt_nxt;
  logic [slcr_pkg::HIST_W-1:0] diff_bits;

  logic signed [slcr_pkg::SAMPLE_W-1:0] smp [slcr_pkg::WINDOW_LEN];
  slcr_pkg::tok_t                       tok [slcr_pkg::WINDOW_LEN+1];

  logic                                 out_valid_r;
  logic                                 out_inverted_r;
  logic signed [slcr_pkg::SAMPLE_W-1:0] out_max_r;
  logic signed [slcr_pkg::SAMPLE_W-1:0] out_min_r;
  logic                                 out_free;

  logic                                 nmatch, imatch;
  logic signed [slcr_pkg::SAMPLE_W:0]   spread;
  logic                                 spread_ok;
  logic                                 emit;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign shift    = in_acc && bstat.take;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r       <= slcr_pkg::SYNC_RESET;
      max_err_r    <= slcr_pkg::ERRORS_RESET;
      min_spread_r <= slcr_pkg::SPREAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        slcr_pkg::CFG_SYNC_PATTERN: sync_r       <= cfg_data[slcr_pkg::HIST_W-1:0];
        slcr_pkg::CFG_MAX_ERRORS:   max_err_r    <= cfg_data[3:0];
        slcr_pkg::CFG_MIN_SPREAD:   min_spread_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  slcr_bitclk u_bitclk (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .sample (in_sample),
    .stat   (bstat)
  );

  // inject the token at the head of the chain on the first scan cycle
  assign tok[0].valid = (state_r == ST_SCAN) && (scan_cnt_r == '0);
  assign tok[0].hi    = slcr_pkg::START_MAX;
  assign tok[0].lo    = slcr_pkg::START_MIN;

  for (genvar k = 0; k < slcr_pkg::WINDOW_LEN; k++) begin : g_cell
    logic signed [slcr_pkg::SAMPLE_W-1:0] cell_in;
    if (k == 0) begin : g_head
      assign cell_in = in_sample;
    end else begin : g_body
      assign cell_in = smp[k-1];
    end
    slcr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (shift),
      .smp_in  (cell_in),
      .smp_out (smp[k]),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign diff_bits = bstat.hist ^ sync_r;

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    err_cnt_nxt  = err_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (shift) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
          err_cnt_nxt  = '0;
        end
      end
      ST_SCAN: begin
        // count one differing history bit a cycle
        if ({1'b0, scan_cnt_r} < (slcr_pkg::CNT_W + 1)'(slcr_pkg::HIST_W)) begin
          err_cnt_nxt = err_cnt_r
                      + slcr_pkg::ERR_W'(diff_bits[scan_cnt_r[slcr_pkg::HIDX_W-1:0]]);
        end
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == slcr_pkg::CNT_W'(slcr_pkg::SCAN_LEN - 1)) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    nmatch    = err_cnt_r <= {1'b0, max_err_r};
    imatch    = (slcr_pkg::ERR_W'(slcr_pkg::HIST_W) - err_cnt_r) <= {1'b0, max_err_r};
    spread    = {tok[slcr_pkg::WINDOW_LEN].hi[slcr_pkg::SAMPLE_W-1],
                 tok[slcr_pkg::WINDOW_LEN].hi}
              - {tok[slcr_pkg::WINDOW_LEN].lo[slcr_pkg::SAMPLE_W-1],
                 tok[slcr_pkg::WINDOW_LEN].lo};
    spread_ok = !spread[slcr_pkg::SAMPLE_W]
                && (spread[slcr_pkg::SAMPLE_W-1:0] > min_spread_r);
    emit      = (state_r == ST_EVAL) && out_free && (nmatch || imatch) && spread_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      err_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      err_cnt_r  <= err_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_inverted_r <= !nmatch;
      out_max_r      <= tok[slcr_pkg::WINDOW_LEN].hi;
      out_min_r      <= tok[slcr_pkg::WINDOW_LEN].lo;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_inverted  = out_inverted_r;
  assign out_level_max = out_max_r;
  assign out_level_min = out_min_r;

`ifndef SYNTHESIS
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    err_cnt_r <= slcr_pkg::ERR_W'(slcr_pkg::HIST_W))
    else $error("sync error count beyond history length");

  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EVAL))
    else $error("result raised outside evaluation");

  a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_max_r > out_min_r))
    else $error("reported max not above min");

  a_scan_from_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && $past(state_r == ST_IDLE) |-> $past(shift))
    else $error("scan started without a bit decision");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sync_level_calibration_receiver: sync frames, noise and
// register sweeps go in; level reports are predicted per sample and checked per beat.
// Depends on slcr_pkg and the receiver RTL.
module tb;

  localparam int SPB = slcr_pkg::SAMPLES_PER_BIT;
  localparam int WIN = slcr_pkg::WINDOW_LEN;
  localparam logic [16:0] BIT_STEP   = 17'(65536 / SPB);
  localparam logic [16:0] EDGE_NUDGE = 17'(65536 / SPB / 32);
  localparam logic [16:0] HALF_TURN  = 17'h08000;
  localparam int LEVEL_FLOOR  = -16000;
  localparam int LEVEL_CEIL   = 16000;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 150;

  typedef enum int { STYLE_FULL, STYLE_FAINT, STYLE_CLAMP } level_style_t;

  typedef struct packed {
    logic                inverted;
    logic signed [15:0]  level_max;
    logic signed [15:0]  level_min;
  } level_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [15:0]   in_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_inverted;
  logic signed [15:0]   out_level_max;
  logic signed [15:0]   out_level_min;
  logic                 cfg_we;
  logic [slcr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [slcr_pkg::CFG_DATA_W-1:0] cfg_data;

  // receiver state and register copies
  logic [15:0]        phase_q;
  logic               sign_q;
  logic [23:0]        history_q;
  logic signed [15:0] ring_q [WIN];
  int                 slot_q;
  logic [23:0]        sync_word;
  logic [3:0]         err_limit;
  logic [15:0]        spread_min;

  level_report_t expected_levels [$];
  level_report_t want;

  int samples_in;
  int results_seen;
  int mismatches;
  int hold_request;
  int cycle_count;
  bit idle_on;

  sync_level_calibration_receiver dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inverted  (out_inverted),
    .out_level_max (out_level_max),
    .out_level_min (out_level_min),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               expected_levels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reset_model;
    phase_q    = '0;
    sign_q     = 1'b0;
    history_q  = '0;
    slot_q     = 0;
    sync_word  = 24'hAAB468;
    err_limit  = 4'd2;
    spread_min = 16'd5;
    foreach (ring_q[k]) ring_q[k] = '0;
  endtask

  // Advance the bit clock by one sample and queue a level report if one is due.
  task automatic predict_levels(input logic signed [15:0] s);
    logic          neg;
    logic [16:0]   ph;
    int            hi;
    int            lo;
    int            n_err;
    int            i_err;
    level_report_t rep;
    neg = s[15];
    ph  = {1'b0, phase_q};
    if (neg != sign_q) begin
      if (ph < HALF_TURN) ph = ph + EDGE_NUDGE;
      else ph = ph - EDGE_NUDGE;
    end
    sign_q  = neg;
    ph      = ph + BIT_STEP;
    phase_q = ph[15:0];
    samples_in++;
    if (!ph[16]) return;

    history_q      = {history_q[22:0], neg};
    ring_q[slot_q] = s;
    slot_q         = (slot_q + 1) % WIN;
    n_err = $countones(history_q ^ sync_word);
    i_err = $countones(history_q ^ ~sync_word);
    if (n_err > int'(err_limit) && i_err > int'(err_limit)) return;

    hi = LEVEL_FLOOR;
    lo = LEVEL_CEIL;
    foreach (ring_q[k]) begin
      if (ring_q[k] > hi) hi = ring_q[k];
      if (ring_q[k] < lo) lo = ring_q[k];
    end
    if (hi - lo <= int'(spread_min)) return;

    rep.inverted  = (n_err <= int'(err_limit)) ? 1'b0 : 1'b1;
    rep.level_max = 16'(hi);
    rep.level_min = 16'(lo);
    expected_levels.push_back(rep);
  endtask

  task automatic check_field(input string name, input logic signed [15:0] exp_v,
                             input logic signed [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_levels.size() == 0) begin
        mismatches++;
        $error("level report with nothing expected: inverted %0d max %0d min %0d",
               out_inverted, out_level_max, out_level_min);
      end else begin
        want = expected_levels.pop_front();
        check_field("inverted", {15'd0, want.inverted}, {15'd0, out_inverted});
        check_field("level_max", want.level_max, out_level_max);
        check_field("level_min", want.level_min, out_level_min);
      end
    end
  end

  // Result side: random stall bursts, or one long hold when requested.
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] value);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
    predict_levels(value);
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    // a bit decision with no report may still be scanning
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slcr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      slcr_pkg::CFG_SYNC_PATTERN: sync_word  = value;
      slcr_pkg::CFG_MAX_ERRORS:   err_limit  = value[3:0];
      slcr_pkg::CFG_MIN_SPREAD:   spread_min = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [23:0] word, input logic [3:0] errs,
                            input logic [15:0] spread);
    drain_results();
    write_reg(slcr_pkg::CFG_SYNC_PATTERN, word);
    write_reg(slcr_pkg::CFG_MAX_ERRORS, {20'd0, errs});
    write_reg(slcr_pkg::CFG_MIN_SPREAD, {8'd0, spread});
  endtask

  task automatic random_config;
    logic [15:0] spread;
    logic [3:0]  errs;
    case ($urandom_range(0, 3))
      0: spread = 16'($urandom_range(0, 20));
      1: spread = 16'($urandom);
      default: spread = 16'($urandom_range(0, 4000));
    endcase
    errs = $urandom_range(0, 1) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 4));
    set_config(24'($urandom), errs, spread);
  endtask

  function automatic logic signed [15:0] level_for(input logic one, input level_style_t style);
    int mag;
    case (style)
      STYLE_FULL:  mag = $urandom_range(0, 32767);
      STYLE_FAINT: mag = $urandom_range(0, 20);
      default:     mag = $urandom_range(15990, 16010);
    endcase
    return one ? 16'(-1 - mag) : 16'(mag);
  endfunction

  function automatic logic [23:0] mask_with_ones(input int count);
    logic [23:0] m;
    m = '0;
    while ($countones(m) < count) m[$urandom_range(0, 23)] = 1'b1;
    return m;
  endfunction

  // Send the low nbits of word, oldest first, about one bit period per bit.
  task automatic send_word(input logic [23:0] word, input int nbits, input level_style_t style);
    int len;
    for (int b = nbits - 1; b >= 0; b--) begin
      len = SPB - 1 + $urandom_range(0, 2);
      for (int k = 0; k < len; k++) send_sample(level_for(word[b], style));
    end
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++) send_sample(16'($urandom));
  endtask

  task automatic test_sample_extremes;
    int picks [25] = '{32767, -32768, 32767, -32768, 0, -1, 0, -1, 1, -2, 16000, -16000,
                       16001, -16001, 15999, -15999, 21845, -21846, 10922, -10923, 255,
                       -256, 32767, 32767, -32768};
    foreach (picks[k]) send_sample(16'(picks[k]));
  endtask

  task automatic test_default_sync_frames;
    send_word(sync_word, 24, STYLE_FULL);
    send_word(~sync_word ^ mask_with_ones(2), 24, STYLE_CLAMP);
  endtask

  task automatic test_register_extremes;
    set_config(24'hFFFFFF, 4'd0, 16'd0);
    send_word(24'hFFFFFF, 24, STYLE_FULL);
    // every history matches the word or its inverse, but no spread can pass
    set_config(24'h000000, 4'd15, 16'hFFFF);
    send_word(24'($urandom), 6, STYLE_FULL);
    set_config(24'($urandom), 4'd13, 16'd0);
    send_word(24'($urandom), 6, STYLE_CLAMP);
  endtask

  task automatic test_both_words_match;
    set_config(24'($urandom), 4'd12, 16'd0);
    send_word(sync_word ^ mask_with_ones(12), 24, STYLE_FULL);
  endtask

  task automatic test_spread_threshold;
    int limits [4] = '{0, 3, 10, 20};
    foreach (limits[k]) begin
      set_config(sync_word, 4'd15, 16'(limits[k]));
      send_word(24'($urandom), (k == 0) ? 24 : 4, STYLE_FAINT);
    end
  endtask

  task automatic test_backpressure;
    set_config(24'($urandom), 4'd15, 16'd0);
    hold_request = 600;
    send_word(24'($urandom), 12, STYLE_FULL);
    drain_results();
  endtask

  task automatic test_random_streams;
    int          first_item;
    int          pick;
    logic [23:0] word;
    first_item = samples_in;
    while (samples_in - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) random_config();
      pick = $urandom_range(0, 9);
      word = $urandom_range(0, 1) ? sync_word : ~sync_word;
      if (pick < 7)
        send_word(word ^ mask_with_ones($urandom_range(0, 3)), 24,
                  level_style_t'($urandom_range(0, 2)));
      else if (pick < 9)
        send_noise($urandom_range(1, 60));
      else
        send_word(word, $urandom_range(1, 23), STYLE_FULL);
    end
  endtask

  task automatic test_steady_stream;
    drain_results();
    idle_on = 1'b0;
    set_config(24'($urandom), 4'd14, 16'd100);
    send_word(24'($urandom), 12, STYLE_FULL);
  endtask

  initial begin : stimulus
    in_valid     = 1'b0;
    in_sample    = '0;
    cfg_we       = 1'b0;
    cfg_index    = slcr_pkg::CFG_SYNC_PATTERN;
    cfg_data     = '0;
    rst_n        = 1'b0;
    samples_in   = 0;
    results_seen = 0;
    mismatches   = 0;
    hold_request = 0;
    cycle_count  = 0;
    idle_on      = 1'b1;
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sample_extremes();
    test_default_sync_frames();
    test_register_extremes();
    test_both_words_match();
    test_spread_threshold();
    test_backpressure();
    test_random_streams();
    test_steady_stream();
    drain_results();

    $display("run covered %0d samples and %0d level reports in %0d cycles",
             samples_in, results_seen, cycle_count);
    $display("register sweeps, long output hold and idle-free tail done, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
